>>> rtl/pah_pkg.sv
// ----------------------------------------------------------------------------
// pah_pkg
// Types and constants shared by the page access heat histogram modules.
// ----------------------------------------------------------------------------
package pah_pkg;

	localparam int PAGE_W   = 14;
	localparam int PAGE_SPAN = 1 << PAGE_W;
	localparam int HIT_W    = 8;
	localparam int COUNT_W  = 15;
	localparam int TOTAL_W  = 22;
	localparam int AVG_W    = 8;
	localparam int EDGE_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_VERY_HIGH_EDGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_EDGE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LOW_TOP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LOW_BOTTOM = 3'd5;

	localparam logic [EDGE_W-1:0] RST_VERY_HIGH_EDGE  = 8'd200;
	localparam logic [EDGE_W-1:0] RST_HIGH_EDGE       = 8'd150;
	localparam logic [EDGE_W-1:0] RST_MIDDLE_EDGE     = 8'd100;
	localparam logic [EDGE_W-1:0] RST_LOW_EDGE        = 8'd64;
	localparam logic [EDGE_W-1:0] RST_VERY_LOW_TOP    = 8'd10;
	localparam logic [EDGE_W-1:0] RST_VERY_LOW_BOTTOM = 8'd5;

	localparam logic [HIT_W-1:0] HIT_MAX = 8'd255;

	typedef enum logic {
		CMD_HIT,
		CMD_REPORT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [PAGE_W-1:0] page;
	} cmd_t;

	typedef struct packed {
		logic [EDGE_W-1:0] very_high_edge;
		logic [EDGE_W-1:0] high_edge;
		logic [EDGE_W-1:0] middle_edge;
		logic [EDGE_W-1:0] low_edge;
		logic [EDGE_W-1:0] very_low_top;
		logic [EDGE_W-1:0] very_low_bottom;
	} edges_t;

	typedef struct packed {
		logic [COUNT_W-1:0] top_count;
		logic [COUNT_W-1:0] mid_count;
		logic [COUNT_W-1:0] low_count;
		logic [COUNT_W-1:0] lower_count;
		logic [COUNT_W-1:0] very_low_count;
		logic [COUNT_W-1:0] least_count;
		logic [COUNT_W-1:0] used_pages;
		logic [TOTAL_W-1:0] total_hits;
		logic [AVG_W-1:0]   average_hits;
	} result_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_RUN,
		B_WALK,
		B_LAST,
		B_DIVSTART,
		B_DIVWAIT
	} back_state_t;

endpackage

>>> rtl/pah_ram.sv
// ----------------------------------------------------------------------------
// pah_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pah_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/pah_front.sv
// ----------------------------------------------------------------------------
// pah_front
// Input handshake and classification of items into store commands.
// ----------------------------------------------------------------------------
module pah_front
	import pah_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              op,
	input  logic [PAGE_W-1:0] page_index,
	input  logic              accessed,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              queue_full,
	input  logic              init_done,
	output logic              push,
	output cmd_t              push_cmd
);

	logic in_range;
	logic counts;

	assign in_range = 32'(page_index) < 32'(DEPTH);
	assign counts   = op || (accessed && in_range);
	assign in_ready = !queue_full && init_done;
	assign push     = in_valid && in_ready && counts;

	always_comb begin
		push_cmd.kind = op ? CMD_REPORT : CMD_HIT;
		push_cmd.page = page_index;
	end

endmodule

>>> rtl/pah_queue.sv
// ----------------------------------------------------------------------------
// pah_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pah_queue
	import pah_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full      = fill_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/pah_div.sv
// ----------------------------------------------------------------------------
// pah_div
// Restoring divider giving one quotient bit per cycle for the average.
// ----------------------------------------------------------------------------
module pah_div
	import pah_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TOTAL_W-1:0] dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [AVG_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(AVG_W);

	logic [TOTAL_W-1:0] rem_q;
	logic [TOTAL_W-1:0] dsh_q;
	logic [AVG_W-1:0]   quot_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic               fits;

	assign fits     = rem_q >= dsh_q;
	assign done     = done_q;
	assign quotient = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= TOTAL_W'({divisor, {(AVG_W-1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[AVG_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= divisor != '0;
			done_q <= divisor == '0;
			step_q <= STEP_W'(AVG_W-1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/pah_back.sv
// ----------------------------------------------------------------------------
// pah_back
// Executes store commands: counter updates, the report walk and the result.
// ----------------------------------------------------------------------------
module pah_back
	import pah_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  edges_t             edges,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               init_done,
	output logic               div_start,
	output logic [TOTAL_W-1:0] div_dividend,
	output logic [COUNT_W-1:0] div_divisor,
	input  logic               div_done,
	input  logic [AVG_W-1:0]   div_quotient,
	output result_t            res,
	output logic               out_valid,
	input  logic               out_ready
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	back_state_t state_q, state_d;

	logic [ADDR_W-1:0] cnt_q;
	logic              cnt_last;
	logic              cnt_step;
	logic              issue;
	logic              issue_walk;
	logic [ADDR_W-1:0] issue_addr;
	logic              acc_clear;
	logic              load_out;

	logic              vld_s1;
	logic              walk_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              fwd_hit_q;
	logic [HIT_W-1:0]  fwd_data_q;
	logic [HIT_W-1:0]  ram_rdata;
	logic [HIT_W-1:0]  data;
	logic [HIT_W-1:0]  heat;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [HIT_W-1:0]  wdata;

	logic b_top, b_mid, b_low, b_lower, b_vlow, b_least;

	logic [COUNT_W-1:0] top_q, mid_q, low_q, lower_q, vlow_q, least_q, used_q;
	logic [TOTAL_W-1:0] total_q;
	result_t            res_q;
	logic               out_valid_q;

	assign cnt_last  = cnt_q == LAST;
	assign init_done = state_q != B_INIT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT: begin
				if (cnt_last) begin
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (q_valid && q_cmd.kind == CMD_REPORT) begin
					state_d = B_WALK;
				end
			end
			B_WALK: begin
				if (cnt_last) begin
					state_d = B_LAST;
				end
			end
			B_LAST: begin
				state_d = B_DIVSTART;
			end
			B_DIVSTART: begin
				state_d = B_DIVWAIT;
			end
			B_DIVWAIT: begin
				if (div_done && (!out_valid_q || out_ready)) begin
					state_d = B_RUN;
				end
			end
			default: begin
				state_d = B_INIT;
			end
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		issue      = 1'b0;
		issue_walk = 1'b0;
		issue_addr = cnt_q;
		acc_clear  = 1'b0;
		cnt_step   = 1'b0;
		div_start  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			B_INIT: begin
				cnt_step = 1'b1;
			end
			B_RUN: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.kind == CMD_HIT) begin
						issue      = 1'b1;
						issue_addr = q_cmd.page[ADDR_W-1:0];
					end else begin
						acc_clear = 1'b1;
					end
				end
			end
			B_WALK: begin
				issue      = 1'b1;
				issue_walk = 1'b1;
				cnt_step   = 1'b1;
			end
			B_DIVSTART: begin
				div_start = 1'b1;
			end
			B_DIVWAIT: begin
				load_out = div_done && (!out_valid_q || out_ready);
			end
			default: begin
			end
		endcase
	end

	assign data = fwd_hit_q ? fwd_data_q : ram_rdata;
	assign heat = data - 1'b1;

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		if (state_q == B_INIT) begin
			we    = 1'b1;
			waddr = cnt_q;
		end else if (vld_s1) begin
			we    = 1'b1;
			wdata = walk_s1 ? '0 : ((data == HIT_MAX) ? HIT_MAX : data + 1'b1);
		end
	end

	pah_ram #(
		.WIDTH(HIT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(issue_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		b_top   = heat < edges.very_high_edge && heat > edges.high_edge;
		b_mid   = heat > edges.middle_edge && heat <= edges.high_edge;
		b_low   = heat <= edges.middle_edge && heat > edges.low_edge;
		b_lower = heat > edges.very_low_top && heat <= edges.low_edge;
		b_vlow  = heat > edges.very_low_bottom && heat <= edges.very_low_top;
		b_least = heat <= edges.very_low_bottom;
	end

	always_ff @(posedge clk) begin
		addr_s1    <= issue_addr;
		walk_s1    <= issue_walk;
		fwd_data_q <= wdata;
		if (acc_clear) begin
			top_q   <= '0;
			mid_q   <= '0;
			low_q   <= '0;
			lower_q <= '0;
			vlow_q  <= '0;
			least_q <= '0;
			used_q  <= '0;
			total_q <= '0;
		end else if (vld_s1 && walk_s1 && data != '0) begin
			top_q   <= top_q + COUNT_W'(b_top);
			mid_q   <= mid_q + COUNT_W'(b_mid);
			low_q   <= low_q + COUNT_W'(b_low);
			lower_q <= lower_q + COUNT_W'(b_lower);
			vlow_q  <= vlow_q + COUNT_W'(b_vlow);
			least_q <= least_q + COUNT_W'(b_least);
			used_q  <= used_q + 1'b1;
			total_q <= total_q + TOTAL_W'(data);
		end
		if (load_out) begin
			res_q.top_count      <= top_q;
			res_q.mid_count      <= mid_q;
			res_q.low_count      <= low_q;
			res_q.lower_count    <= lower_q;
			res_q.very_low_count <= vlow_q;
			res_q.least_count    <= least_q;
			res_q.used_pages     <= used_q;
			res_q.total_hits     <= total_q;
			res_q.average_hits   <= div_quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			fwd_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			vld_s1    <= issue;
			fwd_hit_q <= issue && we && (waddr == issue_addr);
			if (cnt_step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign div_dividend = total_q;
	assign div_divisor  = used_q;
	assign res          = res_q;
	assign out_valid    = out_valid_q;

endmodule

>>> rtl/page_access_heat_histogram.sv
// ----------------------------------------------------------------------------
// page_access_heat_histogram
// Per-page saturating hit counters with a bucketed heat report on request.
// ----------------------------------------------------------------------------
// A request on the input channel is either a page sample (op low) or a
// report (op high). Samples with the accessed bit set and a page below
// PAGE_COUNT add one hit to that page's counter; other samples are dropped
// at once. Samples are taken one per cycle while in_ready is high and pass
// a four-entry queue; each counter update then reads the store and writes it back.
// A report walks the whole store, one counter per cycle, clearing each as it
// goes, then divides the total by the used pages. The walk's length is set
// by the single read port of the counter memory; samples queue behind the
// report meanwhile.
// The result sits in an output register until the receiver takes it; while
// it waits, the next report stops once its walk is done and every request
// queued behind that report waits with it.
// After reset the block sweeps every entry of the store to zero with in_ready
// low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module page_access_heat_histogram
	import pah_pkg::*;
#(
	parameter int PAGE_COUNT = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EDGE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [PAGE_W-1:0]    page_index,
	input  logic                 accessed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COUNT_W-1:0]   top_count,
	output logic [COUNT_W-1:0]   mid_count,
	output logic [COUNT_W-1:0]   low_count,
	output logic [COUNT_W-1:0]   lower_count,
	output logic [COUNT_W-1:0]   very_low_count,
	output logic [COUNT_W-1:0]   least_count,
	output logic [COUNT_W-1:0]   used_pages,
	output logic [TOTAL_W-1:0]   total_hits,
	output logic [AVG_W-1:0]     average_hits
);

	localparam int DEPTH = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;

	edges_t             edges_q;
	logic               queue_full;
	logic               queue_nempty;
	logic               push;
	cmd_t               push_cmd;
	logic               pop;
	cmd_t               pop_cmd;
	logic               init_done;
	logic               div_start;
	logic [TOTAL_W-1:0] div_dividend;
	logic [COUNT_W-1:0] div_divisor;
	logic               div_done;
	logic [AVG_W-1:0]   div_quotient;
	result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q.very_high_edge  <= RST_VERY_HIGH_EDGE;
			edges_q.high_edge       <= RST_HIGH_EDGE;
			edges_q.middle_edge     <= RST_MIDDLE_EDGE;
			edges_q.low_edge        <= RST_LOW_EDGE;
			edges_q.very_low_top    <= RST_VERY_LOW_TOP;
			edges_q.very_low_bottom <= RST_VERY_LOW_BOTTOM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERY_HIGH_EDGE:  edges_q.very_high_edge  <= cfg_data;
				REG_HIGH_EDGE:       edges_q.high_edge       <= cfg_data;
				REG_MIDDLE_EDGE:     edges_q.middle_edge     <= cfg_data;
				REG_LOW_EDGE:        edges_q.low_edge        <= cfg_data;
				REG_VERY_LOW_TOP:    edges_q.very_low_top    <= cfg_data;
				REG_VERY_LOW_BOTTOM: edges_q.very_low_bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pah_front #(
		.DEPTH(DEPTH)
	) u_front (
		.op        (op),
		.page_index(page_index),
		.accessed  (accessed),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.queue_full(queue_full),
		.init_done (init_done),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	pah_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.not_empty(queue_nempty),
		.pop_cmd  (pop_cmd)
	);

	pah_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quotient)
	);

	pah_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.edges       (edges_q),
		.q_valid     (queue_nempty),
		.q_cmd       (pop_cmd),
		.q_pop       (pop),
		.init_done   (init_done),
		.div_start   (div_start),
		.div_dividend(div_dividend),
		.div_divisor (div_divisor),
		.div_done    (div_done),
		.div_quotient(div_quotient),
		.res         (res),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

	assign top_count      = res.top_count;
	assign mid_count      = res.mid_count;
	assign low_count      = res.low_count;
	assign lower_count    = res.lower_count;
	assign very_low_count = res.very_low_count;
	assign least_count    = res.least_count;
	assign used_pages     = res.used_pages;
	assign total_hits     = res.total_hits;
	assign average_hits   = res.average_hits;

endmodule

>>> tb/sv/tb_page_access_heat_histogram.sv
// ----------------------------------------------------------------------------
// tb_page_access_heat_histogram
// Self-checking bench for the page access heat histogram.
// ----------------------------------------------------------------------------
// A driver sends page samples and report requests from a queue. A mirror of
// the hit counters and the edge registers predicts each report, and a monitor
// compares every report field with the oldest prediction. The edges are
// reprogrammed between phases, including all-zero, all-ones, unordered
// settings and writes to unused indices. Both channels pause at random.
// ----------------------------------------------------------------------------
module tb_page_access_heat_histogram;
	import pah_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT  = 200000;
	localparam int BLOCKS_PER_PHASE = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		cmd_kind_t         kind;
		logic [PAGE_W-1:0] page;
		logic              accessed;
	} page_req_t;

	typedef enum {
		BLK_SPARSE,
		BLK_HOT,
		BLK_SATURATE,
		BLK_NOISE
	} block_style_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [EDGE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = 1'b0;
	logic [PAGE_W-1:0]    page_index = '0;
	logic                 accessed = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COUNT_W-1:0]   top_count;
	logic [COUNT_W-1:0]   mid_count;
	logic [COUNT_W-1:0]   low_count;
	logic [COUNT_W-1:0]   lower_count;
	logic [COUNT_W-1:0]   very_low_count;
	logic [COUNT_W-1:0]   least_count;
	logic [COUNT_W-1:0]   used_pages;
	logic [TOTAL_W-1:0]   total_hits;
	logic [AVG_W-1:0]     average_hits;

	page_req_t   pending_reqs[$];
	result_t     expected_reports[$];
	logic [HIT_W-1:0] hit_mirror[PAGE_SPAN];
	edges_t      edge_mirror;
	int          queued_reqs = 0;
	int          accepted_reqs = 0;
	int          mismatch_count = 0;
	int          send_pause = 0;
	int          take_pause = 0;
	int          quiet_cycles = 0;
	bit          sender_idles = 1'b1;
	bit          receiver_stalls = 1'b1;
	page_req_t   next_req;
	result_t     oldest_report;

	page_access_heat_histogram u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.page_index    (page_index),
		.accessed      (accessed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.top_count     (top_count),
		.mid_count     (mid_count),
		.low_count     (low_count),
		.lower_count   (lower_count),
		.very_low_count(very_low_count),
		.least_count   (least_count),
		.used_pages    (used_pages),
		.total_hits    (total_hits),
		.average_hits  (average_hits)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		foreach (hit_mirror[i]) hit_mirror[i] = '0;
		edge_mirror.very_high_edge  = RST_VERY_HIGH_EDGE;
		edge_mirror.high_edge       = RST_HIGH_EDGE;
		edge_mirror.middle_edge     = RST_MIDDLE_EDGE;
		edge_mirror.low_edge        = RST_LOW_EDGE;
		edge_mirror.very_low_top    = RST_VERY_LOW_TOP;
		edge_mirror.very_low_bottom = RST_VERY_LOW_BOTTOM;
	end

	function automatic int draw_pause(bit enabled, int long_max);
		int roll;
		roll = $urandom_range(99);
		if (!enabled || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, long_max);
	endfunction

	// Builds the report that the stored hit counts give, then clears them.
	function automatic result_t take_heat_report();
		int heat, top_n, mid_n, low_n, lower_n, vlow_n, least_n, used_n, total_n, avg_n;
		int vh, h, m, l, vt, vb;
		result_t rpt;
		top_n = 0; mid_n = 0; low_n = 0; lower_n = 0; vlow_n = 0; least_n = 0;
		used_n = 0; total_n = 0; avg_n = 0;
		vh = int'(edge_mirror.very_high_edge);
		h  = int'(edge_mirror.high_edge);
		m  = int'(edge_mirror.middle_edge);
		l  = int'(edge_mirror.low_edge);
		vt = int'(edge_mirror.very_low_top);
		vb = int'(edge_mirror.very_low_bottom);
		for (int i = 0; i < PAGE_SPAN; i++) begin
			heat = int'(hit_mirror[i]) - 1;
			if (heat < vh && heat > h) top_n++;
			if (heat > m && heat <= h) mid_n++;
			if (heat <= m && heat > l) low_n++;
			if (heat > vt && heat <= l) lower_n++;
			if (heat > vb && heat <= vt) vlow_n++;
			if (heat >= 0 && heat <= vb) least_n++;
			if (hit_mirror[i] != '0) begin
				used_n++;
				total_n += int'(hit_mirror[i]);
			end
			hit_mirror[i] = '0;
		end
		if (used_n != 0)
			avg_n = total_n / used_n;
		rpt.top_count      = top_n[COUNT_W-1:0];
		rpt.mid_count      = mid_n[COUNT_W-1:0];
		rpt.low_count      = low_n[COUNT_W-1:0];
		rpt.lower_count    = lower_n[COUNT_W-1:0];
		rpt.very_low_count = vlow_n[COUNT_W-1:0];
		rpt.least_count    = least_n[COUNT_W-1:0];
		rpt.used_pages     = used_n[COUNT_W-1:0];
		rpt.total_hits     = total_n[TOTAL_W-1:0];
		rpt.average_hits   = avg_n[AVG_W-1:0];
		return rpt;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// Request driver: the mirror is updated as each request is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_pause = 0;
		end else begin
			if (in_valid && in_ready) begin
				accepted_reqs++;
				if (op == CMD_REPORT)
					expected_reports.push_back(take_heat_report());
				else if (accessed && int'(page_index) < PAGE_SPAN &&
				         hit_mirror[page_index] != HIT_MAX)
					hit_mirror[page_index] = hit_mirror[page_index] + 1'b1;
			end
			if (!in_valid || in_ready) begin
				if (send_pause > 0) begin
					send_pause--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					op         <= next_req.kind;
					page_index <= next_req.page;
					accessed   <= next_req.accessed;
					in_valid   <= 1'b1;
					send_pause = draw_pause(sender_idles, 60);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Report monitor and receiver stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_pause = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report received with none expected", $time);
					mismatch_count++;
				end else begin
					oldest_report = expected_reports.pop_front();
					check_field("top_count", 32'(oldest_report.top_count),
					            32'(top_count));
					check_field("mid_count", 32'(oldest_report.mid_count),
					            32'(mid_count));
					check_field("low_count", 32'(oldest_report.low_count),
					            32'(low_count));
					check_field("lower_count", 32'(oldest_report.lower_count),
					            32'(lower_count));
					check_field("very_low_count", 32'(oldest_report.very_low_count),
					            32'(very_low_count));
					check_field("least_count", 32'(oldest_report.least_count),
					            32'(least_count));
					check_field("used_pages", 32'(oldest_report.used_pages),
					            32'(used_pages));
					check_field("total_hits", 32'(oldest_report.total_hits),
					            32'(total_hits));
					check_field("average_hits", 32'(oldest_report.average_hits),
					            32'(average_hits));
				end
			end
			if (take_pause > 0) begin
				take_pause--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				take_pause = draw_pause(receiver_stalls, 300);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_req(cmd_kind_t kind, int page, bit acc);
		page_req_t r;
		r.kind     = kind;
		r.page     = page[PAGE_W-1:0];
		r.accessed = acc;
		pending_reqs.push_back(r);
		queued_reqs++;
	endtask

	// One block of samples closed by a report request.
	task automatic queue_block(block_style_t style);
		int hot_pages[4];
		int k, n, n_sat, n_warm;
		foreach (hot_pages[i]) hot_pages[i] = $urandom_range(0, PAGE_SPAN - 1);
		case (style)
			BLK_SPARSE: begin
				n = $urandom_range(5, 30);
				repeat (n) queue_req(CMD_HIT, $urandom_range(0, PAGE_SPAN - 1),
				                     $urandom_range(99) < 85);
			end
			BLK_HOT: begin
				k = $urandom_range(1, 4);
				n = $urandom_range(20, 80);
				repeat (n) begin
					if ($urandom_range(99) < 85)
						queue_req(CMD_HIT, hot_pages[$urandom_range(0, k - 1)], 1'b1);
					else
						queue_req(CMD_HIT, $urandom_range(0, PAGE_SPAN - 1),
						          1'($urandom_range(1)));
				end
			end
			BLK_SATURATE: begin
				hot_pages[1] = (hot_pages[0] + $urandom_range(1, PAGE_SPAN - 1)) % PAGE_SPAN;
				n_sat  = $urandom_range(256, 270);
				n_warm = $urandom_range(150, 205);
				while (n_sat > 0 || n_warm > 0) begin
					if (n_sat > 0 && (n_warm == 0 || $urandom_range(1))) begin
						queue_req(CMD_HIT, hot_pages[0], 1'b1);
						n_sat--;
					end else begin
						queue_req(CMD_HIT, hot_pages[1], 1'b1);
						n_warm--;
					end
				end
			end
			default: begin
				n = $urandom_range(3, 12);
				repeat (n) queue_req(CMD_HIT, $urandom_range(0, PAGE_SPAN - 1), 1'b0);
			end
		endcase
		queue_req(CMD_REPORT, $urandom_range(0, PAGE_SPAN - 1), 1'($urandom_range(1)));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EDGE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_VERY_HIGH_EDGE:  edge_mirror.very_high_edge  = val;
			REG_HIGH_EDGE:       edge_mirror.high_edge       = val;
			REG_MIDDLE_EDGE:     edge_mirror.middle_edge     = val;
			REG_LOW_EDGE:        edge_mirror.low_edge        = val;
			REG_VERY_LOW_TOP:    edge_mirror.very_low_top    = val;
			REG_VERY_LOW_BOTTOM: edge_mirror.very_low_bottom = val;
			default: ;
		endcase
	endtask

	task automatic program_edges(logic [EDGE_W-1:0] vh, logic [EDGE_W-1:0] h,
	                             logic [EDGE_W-1:0] m, logic [EDGE_W-1:0] l,
	                             logic [EDGE_W-1:0] vt, logic [EDGE_W-1:0] vb);
		write_reg(REG_VERY_HIGH_EDGE, vh);
		write_reg(REG_HIGH_EDGE, h);
		write_reg(REG_MIDDLE_EDGE, m);
		write_reg(REG_LOW_EDGE, l);
		write_reg(REG_VERY_LOW_TOP, vt);
		write_reg(REG_VERY_LOW_BOTTOM, vb);
	endtask

	// The sender holds back here until every report has been returned.
	task automatic wait_until_drained();
		@(negedge clk);
		while (accepted_reqs != queued_reqs || expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int roll;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// An empty report, extreme pages, a cleared accessed bit and a report
		// straight after another one.
		queue_req(CMD_REPORT, 0, 1'b0);
		queue_req(CMD_HIT, 0, 1'b1);
		queue_req(CMD_HIT, PAGE_SPAN - 1, 1'b1);
		queue_req(CMD_HIT, PAGE_SPAN - 1, 1'b1);
		queue_req(CMD_HIT, 'h2AAA, 1'b0);
		queue_req(CMD_HIT, 'h1555, 1'b1);
		queue_req(CMD_HIT, 'h3FFF, 1'b0);
		queue_req(CMD_REPORT, PAGE_SPAN - 1, 1'b1);
		queue_req(CMD_REPORT, 'h2AAA, 1'b0);

		for (int phase = 1; phase <= 6; phase++) begin
			wait_until_drained();
			case (phase)
				1: program_edges(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				2: program_edges(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				3: program_edges(8'd40, 8'd30, 8'd20, 8'd12, 8'd6, 8'd2);
				5: begin
					program_edges(RST_VERY_HIGH_EDGE, RST_HIGH_EDGE, RST_MIDDLE_EDGE,
					              RST_LOW_EDGE, RST_VERY_LOW_TOP, RST_VERY_LOW_BOTTOM);
					write_reg(REG_SPARE_LO, EDGE_W'($urandom_range(0, 255)));
					write_reg(REG_SPARE_HI, EDGE_W'($urandom_range(0, 255)));
				end
				default: program_edges(EDGE_W'($urandom_range(0, 80)),
				                       EDGE_W'($urandom_range(0, 80)),
				                       EDGE_W'($urandom_range(0, 80)),
				                       EDGE_W'($urandom_range(0, 40)),
				                       EDGE_W'($urandom_range(0, 20)),
				                       EDGE_W'($urandom_range(0, 10)));
			endcase
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			sender_idles    = (phase != 2);
			receiver_stalls = (phase != 4);
			for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				roll = $urandom_range(99);
				if (blk == 2 && (phase == 3 || phase == 5))
					queue_block(BLK_SATURATE);
				else if (roll < 35)
					queue_block(BLK_SPARSE);
				else if (roll < 85)
					queue_block(BLK_HOT);
				else
					queue_block(BLK_NOISE);
			end
		end

		wait_until_drained();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pah_pkg.sv
rtl/pah_ram.sv
rtl/pah_front.sv
rtl/pah_queue.sv
rtl/pah_div.sv
rtl/pah_back.sv
rtl/page_access_heat_histogram.sv
tb/sv/tb_page_access_heat_histogram.sv
